[hdl/adsrenv_pkg.sv]
// Shared types and constants of the linear ADSR envelope level core.
// Depends on nothing; every module of the core imports it.
package adsrenv_pkg;

  // Time and level formats.
  localparam int TIME_W = 32;
  localparam int FRAC_W = 16;
  localparam int LVL_W  = FRAC_W + 1;
  localparam int LEN_W  = 24;
  localparam int NUM_W  = LVL_W + LEN_W;
  localparam int CFG_W  = LEN_W;
  localparam int IDX_W  = 2;

  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_W;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_RELEASE = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SUSTAIN = 2'd3;

  // One item on its way through the divider cells. The accumulator holds
  // the partial remainder above the numerator bits still to come, and the
  // quotient bits collect at its bottom.
  typedef struct packed {
    logic [NUM_W-1:0] acc;
    logic [LEN_W-1:0] dvsr;
    logic [LVL_W-1:0] base;
    logic             sub;
  } adsrenv_lane_t;

endpackage

[hdl/adsr_envelope_level_core.sv]
// Linear ADSR envelope level core: top level with configuration registers.
// Throughput: one item per cycle; busy stays low. The pipeline has four front
// stages, seventeen one-bit divider cells and an output register.
// Reset (synchronous, rst_n low) clears all valid flags and loads the
// registers with zero lengths and full-scale sustain. Depends on adsrenv_pkg.
module adsr_envelope_level_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [adsrenv_pkg::TIME_W-1:0]    in_note_on_time,
  input  logic [adsrenv_pkg::TIME_W-1:0]    in_note_off_time,
  input  logic [adsrenv_pkg::TIME_W-1:0]    in_sample_time,
  output logic                              out_valid,
  output logic [adsrenv_pkg::LVL_W-1:0]     out_env_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adsrenv_pkg::IDX_W-1:0]     cfg_index,
  input  logic [adsrenv_pkg::CFG_W-1:0]     cfg_data
);
  import adsrenv_pkg::*;

  localparam int PIPE_LAT = 4 + LVL_W + 1;

  logic [LEN_W-1:0]  att_len_r;
  logic [LEN_W-1:0]  dec_len_r;
  logic [LEN_W-1:0]  rel_len_r;
  logic [LVL_W-1:0]  sus_lvl_r;
  logic [LVL_W-1:0]  sus_sat;
  logic              accept;

  logic              cell_vld  [LVL_W+1];
  adsrenv_lane_t     cell_lane [LVL_W+1];

  logic [LVL_W-1:0]  quot;
  logic [LVL_W-1:0]  level_nxt;
  logic              out_valid_r;
  logic [LVL_W-1:0]  out_env_level_r;

  // The pipeline never stalls, so a start beat is always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_len_r <= '0;
      dec_len_r <= '0;
      rel_len_r <= '0;
      sus_lvl_r <= LVL_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTACK:  att_len_r <= cfg_data;
        CFG_DECAY:   dec_len_r <= cfg_data;
        CFG_RELEASE: rel_len_r <= cfg_data;
        CFG_SUSTAIN: sus_lvl_r <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sustain above full scale counts as full scale.
  assign sus_sat = (sus_lvl_r > LVL_ONE) ? LVL_ONE : sus_lvl_r;

  adsrenv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .note_on  (in_note_on_time),
    .note_off (in_note_off_time),
    .smp_time (in_sample_time),
    .att_len  (att_len_r),
    .dec_len  (dec_len_r),
    .rel_len  (rel_len_r),
    .sus_lvl  (sus_sat),
    .out_vld  (cell_vld[0]),
    .out_lane (cell_lane[0])
  );

  // Row of divider cells, one quotient bit each.
  for (genvar k = 0; k < LVL_W; k++) begin : g_cell
    adsrenv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (cell_vld[k]),
      .in_lane  (cell_lane[k]),
      .out_vld  (cell_vld[k+1]),
      .out_lane (cell_lane[k+1])
    );
  end

  // Final level: the quotient itself if sub is clear, else base minus it.
  assign quot      = cell_lane[LVL_W].acc[LVL_W-1:0];
  assign level_nxt = cell_lane[LVL_W].sub ? (cell_lane[LVL_W].base - quot) : quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cell_vld[LVL_W];
    end
    out_env_level_r <= level_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_env_level = out_env_level_r;

`ifndef SYNTHESIS
  // Every result beat goes back to an earlier start beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("adsr_envelope_level_core: result without matching start");

  // The level never exceeds full scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_env_level <= LVL_ONE))
    else $error("adsr_envelope_level_core: level above full scale");
`endif

endmodule

[hdl/adsrenv_front.sv]
// Front end of the envelope core: phase decision, operand selection and the
// product that feeds the divider cells. Depends on adsrenv_pkg.
module adsrenv_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic [adsrenv_pkg::TIME_W-1:0]     note_on,
  input  logic [adsrenv_pkg::TIME_W-1:0]     note_off,
  input  logic [adsrenv_pkg::TIME_W-1:0]     smp_time,
  input  logic [adsrenv_pkg::LEN_W-1:0]      att_len,
  input  logic [adsrenv_pkg::LEN_W-1:0]      dec_len,
  input  logic [adsrenv_pkg::LEN_W-1:0]      rel_len,
  input  logic [adsrenv_pkg::LVL_W-1:0]      sus_lvl,
  output logic                               out_vld,
  output adsrenv_pkg::adsrenv_lane_t         out_lane
);
  import adsrenv_pkg::*;

  // Stage 1 signals: effective note-off and time since note-on.
  logic [TIME_W:0]   held;
  logic [LEN_W:0]    ad_len;
  logic              held_short;
  logic [TIME_W:0]   off_eff_nxt;
  logic [TIME_W:0]   d_nxt;
  logic              vld1_r;
  logic [TIME_W:0]   off_eff1_r;
  logic [TIME_W:0]   d1_r;
  logic [TIME_W-1:0] t1_r;

  // Stage 2 signals: release and attack boundaries.
  logic [TIME_W+1:0] rdiff;
  logic [TIME_W+1:0] da;
  logic              vld2_r;
  logic              rel2_r;
  logic              dneg2_r;
  logic              att2_r;
  logic [TIME_W-1:0] r2_r;
  logic [TIME_W-1:0] da2_r;
  logic [LEN_W-1:0]  d2_r;

  // Stage 3 signals: operands of the one division.
  logic              r_lt;
  logic              dec_lt;
  logic [LVL_W-1:0]  factor_nxt;
  logic [LEN_W-1:0]  count_nxt;
  logic [LEN_W-1:0]  dvsr_nxt;
  logic [LVL_W-1:0]  base_nxt;
  logic              sub_nxt;
  logic              vld3_r;
  logic [LVL_W-1:0]  factor3_r;
  logic [LEN_W-1:0]  count3_r;
  logic [LEN_W-1:0]  dvsr3_r;
  logic [LVL_W-1:0]  base3_r;
  logic              sub3_r;

  // Stage 4: product register.
  logic              vld4_r;
  adsrenv_lane_t     lane4_r;

  // Stage 1: a note held shorter than attack plus decay is released late.
  assign held        = {1'b0, note_off} - {1'b0, note_on};
  assign ad_len      = {1'b0, att_len} + {1'b0, dec_len};
  assign held_short  = $signed(held) < $signed({(TIME_W-LEN_W)'(0), ad_len});
  assign off_eff_nxt = held_short ? ({1'b0, note_on} + (TIME_W+1)'(ad_len))
                                  : {1'b0, note_off};
  assign d_nxt       = {1'b0, smp_time} - {1'b0, note_on};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    off_eff1_r <= off_eff_nxt;
    d1_r       <= d_nxt;
    t1_r       <= smp_time;
  end

  // Stage 2: release starts at the effective note-off; attack ends at A.
  assign rdiff = {2'b00, t1_r} - {1'b0, off_eff1_r};
  assign da    = {d1_r[TIME_W], d1_r} - (TIME_W+2)'(att_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    rel2_r  <= !rdiff[TIME_W+1];
    dneg2_r <= d1_r[TIME_W];
    att2_r  <= da[TIME_W+1];
    r2_r    <= rdiff[TIME_W-1:0];
    da2_r   <= da[TIME_W-1:0];
    d2_r    <= d1_r[LEN_W-1:0];
  end

  // Stage 3: pick the phase and set up factor * count / divisor. Phases that
  // need no division get a zero product over a divisor of one.
  assign r_lt   = r2_r < TIME_W'(rel_len);
  assign dec_lt = da2_r < TIME_W'(dec_len);

  always_comb begin
    factor_nxt = '0;
    count_nxt  = '0;
    dvsr_nxt   = LEN_W'(1);
    base_nxt   = '0;
    sub_nxt    = 1'b0;
    if (rel2_r) begin
      if (r_lt) begin
        factor_nxt = sus_lvl;
        count_nxt  = r2_r[LEN_W-1:0];
        dvsr_nxt   = rel_len;
        base_nxt   = sus_lvl;
        sub_nxt    = 1'b1;
      end
    end else if (!dneg2_r) begin
      if (att2_r) begin
        factor_nxt = LVL_ONE;
        count_nxt  = d2_r;
        dvsr_nxt   = att_len;
      end else if (dec_lt) begin
        factor_nxt = LVL_ONE - sus_lvl;
        count_nxt  = da2_r[LEN_W-1:0];
        dvsr_nxt   = dec_len;
        base_nxt   = LVL_ONE;
        sub_nxt    = 1'b1;
      end else begin
        base_nxt   = sus_lvl;
        sub_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    factor3_r <= factor_nxt;
    count3_r  <= count_nxt;
    dvsr3_r   <= dvsr_nxt;
    base3_r   <= base_nxt;
    sub3_r    <= sub_nxt;
  end

  // Stage 4: the numerator of the division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    lane4_r.acc  <= NUM_W'(factor3_r) * NUM_W'(count3_r);
    lane4_r.dvsr <= dvsr3_r;
    lane4_r.base <= base3_r;
    lane4_r.sub  <= sub3_r;
  end

  assign out_vld  = vld4_r;
  assign out_lane = lane4_r;

`ifndef SYNTHESIS
  // The count of a dividing phase is always below its divisor, so the
  // quotient fits the level width and no division by zero reaches the cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> (count3_r < dvsr3_r))
    else $error("adsrenv_front: division count not below divisor");
`endif

endmodule

[hdl/adsrenv_cell.sv]
// One restoring division cell: develops one quotient bit per beat and hands
// the item to the next cell. Depends on adsrenv_pkg.
module adsrenv_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  adsrenv_pkg::adsrenv_lane_t  in_lane,
  output logic                        out_vld,
  output adsrenv_pkg::adsrenv_lane_t  out_lane
);
  import adsrenv_pkg::*;

  logic [LEN_W:0]   trial;
  logic             q_bit;
  logic [LEN_W:0]   rem;
  adsrenv_lane_t    lane_nxt;
  logic             vld_r;
  adsrenv_lane_t    lane_r;

  // Bring down the next numerator bit and try the subtraction.
  assign trial = in_lane.acc[NUM_W-1:LVL_W-1];
  assign q_bit = trial >= {1'b0, in_lane.dvsr};
  assign rem   = q_bit ? (trial - {1'b0, in_lane.dvsr}) : trial;

  always_comb begin
    lane_nxt     = in_lane;
    lane_nxt.acc = {rem[LEN_W-1:0], in_lane.acc[LVL_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    lane_r <= lane_nxt;
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;

`ifndef SYNTHESIS
  // The partial remainder stays below the divisor after every step.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (lane_r.acc[NUM_W-1:LVL_W] < lane_r.dvsr))
    else $error("adsrenv_cell: partial remainder not below divisor");
`endif

endmodule

[tb/tb_adsr_envelope_level_core.sv]
// Self-checking testbench for the linear ADSR envelope level core.
// Depends on adsrenv_pkg and adsr_envelope_level_core, and through it on adsrenv_front and adsrenv_cell.
module tb_adsr_envelope_level_core;
  import adsrenv_pkg::*;

  localparam longint UNITY = longint'(LVL_ONE);

  typedef struct {
    logic [TIME_W-1:0] on_t;
    logic [TIME_W-1:0] off_t;
    logic [TIME_W-1:0] smp_t;
  } note_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [TIME_W-1:0] in_note_on_time = '0;
  logic [TIME_W-1:0] in_note_off_time = '0;
  logic [TIME_W-1:0] in_sample_time = '0;
  logic              out_valid;
  logic [LVL_W-1:0]  out_env_level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Shadow copy of the envelope registers, loaded as each write beat lands.
  logic [LEN_W-1:0] atk_len = '0;
  logic [LEN_W-1:0] dcy_len = '0;
  logic [LEN_W-1:0] rel_len = '0;
  logic [LVL_W-1:0] sus_lvl = LVL_ONE;

  note_t            pending_notes[$];
  logic [LVL_W-1:0] expected_levels[$];
  int               gap_pct = 36;
  int               notes_taken = 0;
  int               levels_checked = 0;
  int               errors = 0;
  int               settings_used = 0;

  adsr_envelope_level_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_note_on_time  (in_note_on_time),
    .in_note_off_time (in_note_off_time),
    .in_sample_time   (in_sample_time),
    .out_valid        (out_valid),
    .out_env_level    (out_env_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Envelope level at the query time, with differences taken in 64 bits so
  // that nothing wraps.
  function automatic logic [LVL_W-1:0] envelope_level(input logic [TIME_W-1:0] on_t,
                                                       input logic [TIME_W-1:0] off_t,
                                                       input logic [TIME_W-1:0] smp_t);
    longint on_l, off_l, t_l, a_l, d_l, r_l, s_l, dt, rt;
    on_l  = {32'h0, on_t};
    off_l = {32'h0, off_t};
    t_l   = {32'h0, smp_t};
    a_l   = {40'h0, atk_len};
    d_l   = {40'h0, dcy_len};
    r_l   = {40'h0, rel_len};
    s_l   = (sus_lvl > LVL_ONE) ? UNITY : {47'h0, sus_lvl};
    // A hold shorter than attack plus decay pushes the release back.
    if (off_l - on_l < a_l + d_l)
      off_l = on_l + a_l + d_l;
    if (off_l <= t_l) begin
      rt = t_l - off_l;
      if (rt < r_l)
        return LVL_W'(s_l - (s_l * rt) / r_l);
      return '0;
    end
    dt = t_l - on_l;
    if (dt < 0)
      return '0;
    if (dt < a_l)
      return LVL_W'((dt * UNITY) / a_l);
    dt -= a_l;
    if (dt < d_l)
      return LVL_W'(UNITY - ((UNITY - s_l) * dt) / d_l);
    return LVL_W'(s_l);
  endfunction

  // Driver: holds a note while busy, records the expected level on each
  // accepted beat and idles at random between beats.
  always @(posedge clk) begin : drive_notes
    note_t nxt;
    if (rst_n && !(start && busy)) begin
      if (start) begin
        expected_levels = {expected_levels,
                           envelope_level(in_note_on_time, in_note_off_time,
                                          in_sample_time)};
        notes_taken++;
      end
      if (pending_notes.size() > 0 && $urandom_range(99) >= gap_pct) begin
        nxt = pending_notes.pop_front();
        in_note_on_time  <= nxt.on_t;
        in_note_off_time <= nxt.off_t;
        in_sample_time   <= nxt.smp_t;
        start            <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result beat is compared with the oldest expected level.
  always @(posedge clk) begin : check_levels
    logic [LVL_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: env_level expected none, got %0d", $time, out_env_level);
      end else begin
        want = expected_levels.pop_front();
        levels_checked++;
        if (out_env_level !== want) begin
          errors++;
          $display("%0t: env_level expected %0d, got %0d", $time, want, out_env_level);
        end
      end
    end
  end

  task automatic queue_note(input logic [TIME_W-1:0] on_t, input logic [TIME_W-1:0] off_t,
                            input logic [TIME_W-1:0] smp_t);
    note_t n;
    n.on_t  = on_t;
    n.off_t = off_t;
    n.smp_t = smp_t;
    pending_notes = {pending_notes, n};
  endtask

  // Waits until every queued note has been taken and every level has come
  // back, then lets the pipeline empty out.
  task automatic drain;
    while (pending_notes.size() > 0 || start || expected_levels.size() > 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTACK:  atk_len = val;
      CFG_DECAY:   dcy_len = val;
      CFG_RELEASE: rel_len = val;
      CFG_SUSTAIN: sus_lvl = val[LVL_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_envelope(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
                              input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] s);
    drain();
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_SUSTAIN, s);
    settings_used++;
  endtask

  function automatic logic [CFG_W-1:0] pick_length;
    case ($urandom_range(3))
      0:       return '0;
      1:       return CFG_W'($urandom_range(1, 64));
      2:       return CFG_W'($urandom_range(65, 4096));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_sustain;
    case ($urandom_range(4))
      0:       return '0;
      1:       return CFG_W'(LVL_ONE);
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Mostly well-formed notes whose query time falls in or near the envelope,
  // some aimed at phase boundaries, and a share of fully random noise.
  task automatic queue_random_notes(input int count);
    longint a, d, r, on_l, off_l, eff, hold, t_l;
    logic [TIME_W-1:0] on_t;
    int kind;
    a = atk_len;
    d = dcy_len;
    r = rel_len;
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        queue_note($urandom, $urandom, $urandom);
      end else begin
        on_t = ($urandom_range(9) == 0) ? ~TIME_W'($urandom_range(4096)) : TIME_W'($urandom);
        on_l = {32'h0, on_t};
        case ($urandom_range(3))
          0:       hold = -longint'($urandom_range(1, 1000));
          1:       hold = $urandom_range(0, int'(a + d));
          default: hold = a + d + $urandom_range(0, int'(a + d + r + 64));
        endcase
        off_l = on_l + hold;
        eff = (hold < a + d) ? on_l + a + d : off_l;
        if (kind < 40) begin
          case ($urandom_range(4))
            0:       t_l = on_l;
            1:       t_l = on_l + a;
            2:       t_l = on_l + a + d;
            3:       t_l = eff;
            default: t_l = eff + r;
          endcase
          t_l = t_l + $urandom_range(0, 2) - 1;
        end else begin
          t_l = on_l - 8 + $urandom_range(0, int'(eff - on_l + r + 24));
        end
        queue_note(on_t, TIME_W'(off_l), TIME_W'(t_l));
      end
    end
  endtask

  initial begin : run_test
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: no attack, decay or release.
    queue_note(32'd0, 32'd0, 32'd0);
    queue_note(32'd10, 32'd20, 32'd15);
    queue_note(32'd10, 32'd20, 32'd20);

    // One point in every phase, on its boundaries and in the clamped cases.
    set_envelope(24'd100, 24'd200, 24'd300, 24'd30000);
    queue_note(32'd1000, 32'd2000, 32'd999);
    queue_note(32'd1000, 32'd2000, 32'd1000);
    queue_note(32'd1000, 32'd2000, 32'd1050);
    queue_note(32'd1000, 32'd2000, 32'd1100);
    queue_note(32'd1000, 32'd2000, 32'd1250);
    queue_note(32'd1000, 32'd2000, 32'd1300);
    queue_note(32'd1000, 32'd2000, 32'd2000);
    queue_note(32'd1000, 32'd2000, 32'd2150);
    queue_note(32'd1000, 32'd2000, 32'd2300);
    queue_note(32'd1000, 32'd1100, 32'd1350);
    queue_note(32'd1000, 32'd500, 32'd1299);
    queue_note(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_note(32'hFFFF_FFFF, 32'd0, 32'd0);
    queue_note(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFA0);

    // Longest phases, with a sustain above full scale that must saturate.
    set_envelope(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    queue_note(32'd0, 32'd0, 32'h00FF_FFFF);
    queue_note(32'd0, 32'd0, 32'h01FF_FFFD);
    queue_note(32'd5, 32'd5, 32'hFFFF_FFFF);
    queue_note(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);

    // Zero attack and release with a silent sustain.
    set_envelope(24'd0, 24'd50, 24'd0, 24'd0);
    queue_note(32'd100, 32'd100, 32'd100);
    queue_note(32'd100, 32'd100, 32'd150);
    queue_note(32'd100, 32'd400, 32'd200);

    // Random settings and notes; the sender idles more in the middle rounds and not at all in the last two.
    for (int k = 0; k < 6; k++) begin
      set_envelope(pick_length(), pick_length(), pick_length(), pick_sustain());
      gap_pct = (k < 2) ? 36 : (k < 4) ? 61 : 0;
      queue_random_notes(80);
    end

    drain();
    if (expected_levels.size() != 0) begin
      errors++;
      $display("%0t: %0d expected levels never arrived", $time, expected_levels.size());
    end
    $display("Ran %0d notes under %0d envelope settings; %0d levels checked, %0d errors.",
             notes_taken, settings_used + 1, levels_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin : watchdog
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
